@@ rtl/core/psv_pkg.sv @@
package psv_pkg;

  // Part table
  localparam int unsigned MaxParts = 256;
  localparam int unsigned PartIdxW = $clog2(MaxParts);
  localparam int unsigned PartCntW = PartIdxW + 1;

  // Command queue between parser and area engine (power of two)
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // Fixed-point scale of coordinates
  localparam int FracBits = 32;

  localparam logic [31:0] FileCode     = 32'd9994;
  localparam logic [31:0] VersionCode  = 32'd1000;
  localparam logic [31:0] ShapePolygon = 32'd5;
  localparam logic [31:0] ShapeNull    = 32'd0;
  localparam logic [63:0] LonLimit     = 64'h4066_8000_0000_0000;
  localparam logic [63:0] LatLimit     = 64'h4056_8000_0000_0000;

  typedef enum logic [1:0] {
    KIND_RING   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_TRUNC      = 4'd1,
    ERR_FILE_CODE  = 4'd2,
    ERR_VERSION    = 4'd3,
    ERR_SHAPE      = 4'd4,
    ERR_COORD      = 4'd5,
    ERR_LENGTH     = 4'd6,
    ERR_MALFORMED  = 4'd7,
    ERR_DEGENERATE = 4'd8,
    ERR_PARTS      = 4'd9
  } err_e;

  // Non-ring result (accept or error)
  typedef struct packed {
    logic        v;
    kind_e       kind;
    logic [31:0] rec;
    err_e        err;
  } ev_t;

  // One entry of the parser-to-engine queue
  typedef struct packed {
    logic        sof;
    logic        pt;
    logic        pt_first;
    logic        pt_last;
    logic [31:0] pt_rec;
    logic [7:0]  pt_part;
    logic [63:0] x_bits;
    logic [63:0] y_bits;
    ev_t         ev;
  } cmd_t;

  function automatic ev_t mk_err(err_e e, logic [31:0] r);
    ev_t x;
    x.v    = 1'b1;
    x.kind = KIND_ERROR;
    x.rec  = r;
    x.err  = e;
    return x;
  endfunction

endpackage

@@ rtl/core/psv_queue.sv @@
module psv_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  psv_pkg::cmd_t   push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output psv_pkg::cmd_t   pop_data_o,
  output logic            empty_o
);
  import psv_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o     = cnt_q == (QPtrW + 1)'(QDepth);
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue underflow");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
`endif

endmodule

@@ rtl/core/psv_front.sv @@
module psv_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    data_byte_i,
  input  logic          start_of_file_i,
  input  logic [32:0]   file_length_i,
  input  logic          q_full_i,
  output logic          push_o,
  output psv_pkg::cmd_t cmd_o
);
  import psv_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_RECHDR  = 3'b010,
    PH_CONTENT = 3'b100
  } phase_e;

  phase_e phase_q, phase_d, s_phase;
  logic [33:0] off_q, off_d, s_off, decl_q, decl_d, s_decl;
  logic [33:0] roff_q, roff_d, s_roff, clen_q, clen_d, s_clen;
  logic pend_q, pend_d, s_pend, stop_q, stop_d, s_stop;
  logic [31:0] exp_q, exp_d, s_exp, cur_q, cur_d, s_cur;
  logic [31:0] parts_q, parts_d, s_parts, pts_q, pts_d, s_pts;
  logic [PartCntW-1:0] cp_q, cp_d, s_cp;
  logic [63:0] ba_q, ba_d, s_ba, px_q, px_d, s_px;
  logic [31:0] start_q, start_d, s_start, end_q, end_d, s_end, pent_q, pent_d, s_pent;
  logic end_rd_q, end_rd_d, s_end_rd;

  logic [31:0] tbl_q [MaxParts];
  logic [31:0] tbl_rd_q;

  logic acc, sof, do_bnd;
  logic [63:0] ba_n;
  logic [31:0] le, be, idx, pnum, cur_end, cp_plus2;
  logic [33:0] off1, rem7, cl_n, rel, bnd_rem;
  logic [37:0] total;
  logic [34:0] pstart;
  logic [3:0]  pos;
  logic wr_en, rd_en;
  logic [PartIdxW-1:0] wr_addr, rd_addr;
  ev_t  ev;
  logic pt, pt_first, pt_last;

  assign in_ready_o = !q_full_i;
  assign acc = in_valid_i && !q_full_i;
  assign sof = start_of_file_i;

  // A file start clears parse state before this item is parsed
  assign s_phase  = sof ? PH_HEADER : phase_q;
  assign s_off    = sof ? '0 : off_q;
  assign s_decl   = sof ? '0 : decl_q;
  assign s_roff   = sof ? '0 : roff_q;
  assign s_clen   = sof ? '0 : clen_q;
  assign s_pend   = sof ? 1'b0 : pend_q;
  assign s_stop   = sof ? 1'b0 : stop_q;
  assign s_exp    = sof ? 32'd1 : exp_q;
  assign s_cur    = sof ? '0 : cur_q;
  assign s_parts  = sof ? '0 : parts_q;
  assign s_pts    = sof ? '0 : pts_q;
  assign s_cp     = sof ? '0 : cp_q;
  assign s_ba     = sof ? '0 : ba_q;
  assign s_px     = sof ? '0 : px_q;
  assign s_start  = sof ? '0 : start_q;
  assign s_end    = sof ? '0 : end_q;
  assign s_pent   = sof ? '0 : pent_q;
  assign s_end_rd = sof ? 1'b0 : end_rd_q;

  assign ba_n     = {data_byte_i, s_ba[63:8]};
  assign le       = ba_n[63:32];
  assign be       = {le[7:0], le[15:8], le[23:16], le[31:24]};
  assign off1     = s_off + 34'd1;
  assign rem7     = (s_decl > s_off) ? s_decl - off1 : '0;
  assign cl_n     = {1'b0, be, 1'b0};
  assign bnd_rem  = s_decl - off1;
  assign total    = 38'd44 + {4'b0, s_parts, 2'b0} + {2'b0, le, 4'b0};
  assign pstart   = 35'd44 + {1'b0, s_parts, 2'b0};
  assign rel      = s_roff - pstart[33:0];
  assign pos      = rel[3:0];
  assign pnum     = {2'b0, rel[33:4]};
  assign idx      = 32'((s_roff - 34'd44) >> 2);
  assign cur_end  = s_end_rd ? tbl_rd_q : s_end;
  assign cp_plus2 = 32'(s_cp) + 32'd2;

  always_comb begin
    phase_d  = s_phase;  off_d   = s_off;   decl_d  = s_decl;  roff_d  = s_roff;
    clen_d   = s_clen;   pend_d  = s_pend;  stop_d  = s_stop;  exp_d   = s_exp;
    cur_d    = s_cur;    parts_d = s_parts; pts_d   = s_pts;   cp_d    = s_cp;
    ba_d     = s_ba;     px_d    = s_px;    start_d = s_start; end_d   = s_end;
    pent_d   = s_pent;   end_rd_d = s_end_rd;
    ev       = '{v: 1'b0, kind: KIND_ERROR, rec: '0, err: ERR_NONE};
    pt = 1'b0; pt_first = 1'b0; pt_last = 1'b0;
    wr_en = 1'b0; rd_en = 1'b0; wr_addr = '0; rd_addr = '0;
    do_bnd = 1'b0;
    if (!s_stop) begin
      ba_d   = ba_n;
      off_d  = off1;
      roff_d = s_roff + 34'd1;
      unique case (s_phase)
        PH_HEADER: begin
          if (s_off == 34'd0 && file_length_i < 33'd100) begin
            ev = mk_err(ERR_TRUNC, '0); stop_d = 1'b1;
          end else if (s_off == 34'd3 && be != FileCode) begin
            ev = mk_err(ERR_FILE_CODE, '0); stop_d = 1'b1;
          end else if (s_off == 34'd27) begin
            decl_d = cl_n;
            pend_d = cl_n != {1'b0, file_length_i};
          end else if (s_off == 34'd31 && le != VersionCode) begin
            ev = mk_err(ERR_VERSION, '0); stop_d = 1'b1;
          end else if (s_off == 34'd35 && le != ShapePolygon) begin
            ev = mk_err(ERR_SHAPE, '0); stop_d = 1'b1;
          end else if ((s_off == 34'd43 || s_off == 34'd51 || s_off == 34'd59 ||
                        s_off == 34'd67) && ba_n[62:52] == 11'h7FF) begin
            ev = mk_err(ERR_COORD, '0); stop_d = 1'b1;
          end else if (s_off == 34'd67 && s_pend) begin
            ev = mk_err(ERR_LENGTH, '0); stop_d = 1'b1;
          end else if (s_off == 34'd99) begin
            do_bnd = 1'b1;
          end
        end
        PH_RECHDR: begin
          if (s_roff == 34'd3) begin
            cur_d = be;
            if (be != s_exp) begin
              ev = mk_err(ERR_MALFORMED, be); stop_d = 1'b1;
            end else begin
              exp_d = s_exp + 32'd1;
            end
          end else if (s_roff == 34'd7) begin
            clen_d = cl_n;
            if (cl_n < 34'd4 || cl_n > rem7) begin
              ev = mk_err(ERR_TRUNC, s_cur); stop_d = 1'b1;
            end else begin
              phase_d = PH_CONTENT;
              roff_d  = '0;
            end
          end
        end
        PH_CONTENT: begin
          if (s_roff == 34'd3) begin
            if (le == ShapeNull) begin
              if (s_clen != 34'd4) begin
                ev = mk_err(ERR_MALFORMED, s_cur); stop_d = 1'b1;
              end
            end else if (le != ShapePolygon) begin
              ev = mk_err(ERR_SHAPE, s_cur); stop_d = 1'b1;
            end else if (s_clen < 34'd44) begin
              ev = mk_err(ERR_MALFORMED, s_cur); stop_d = 1'b1;
            end
          end else if ((s_roff == 34'd11 || s_roff == 34'd19 || s_roff == 34'd27 ||
                        s_roff == 34'd35) && ba_n[62:52] == 11'h7FF) begin
            ev = mk_err(ERR_COORD, s_cur); stop_d = 1'b1;
          end else if (s_roff == 34'd39) begin
            parts_d = le;
          end else if (s_roff == 34'd43) begin
            pts_d = le;
            if (s_parts == '0 || le == '0 || s_parts > le || total != {4'b0, s_clen}) begin
              ev = mk_err(ERR_MALFORMED, s_cur); stop_d = 1'b1;
            end else if (s_parts > 32'(MaxParts)) begin
              ev = mk_err(ERR_PARTS, s_cur); stop_d = 1'b1;
            end else begin
              cp_d = '0;
            end
          end else if (s_roff >= 34'd44) begin
            if ({1'b0, s_roff} < pstart) begin
              // part table entry complete on its fourth byte
              if (s_roff[1:0] == 2'd3) begin
                if ((idx == '0 && le != '0) || le >= s_pts || (idx != '0 && le <= s_pent) ||
                    idx >= 32'(MaxParts)) begin
                  ev = mk_err(ERR_MALFORMED, s_cur); stop_d = 1'b1;
                end else begin
                  wr_en   = 1'b1;
                  wr_addr = idx[PartIdxW-1:0];
                  pent_d  = le;
                  if (idx + 32'd1 == s_parts) begin
                    cp_d    = '0;
                    start_d = '0;
                    if (s_parts == 32'd1) begin
                      end_d = s_pts; end_rd_d = 1'b0;
                    end else if (idx == 32'd1) begin
                      end_d = le; end_rd_d = 1'b0;
                    end else begin
                      rd_en = 1'b1; rd_addr = PartIdxW'(1); end_rd_d = 1'b1;
                    end
                  end
                end
              end
            end else begin
              if (pos == 4'd0 && pnum == s_start && (cur_end - s_start) < 32'd4) begin
                ev = mk_err(ERR_DEGENERATE, s_cur); stop_d = 1'b1;
              end else if (pos == 4'd7) begin
                if ({1'b0, ba_n[62:0]} > LonLimit) begin
                  ev = mk_err(ERR_COORD, s_cur); stop_d = 1'b1;
                end else begin
                  px_d = ba_n;
                end
              end else if (pos == 4'd15) begin
                if ({1'b0, ba_n[62:0]} > LatLimit) begin
                  ev = mk_err(ERR_COORD, s_cur); stop_d = 1'b1;
                end else begin
                  pt       = 1'b1;
                  pt_first = pnum == s_start;
                  pt_last  = pnum + 32'd1 == cur_end;
                  if (pt_last) begin
                    cp_d    = s_cp + 1'b1;
                    start_d = cur_end;
                    if (cp_plus2 < s_parts) begin
                      rd_en = 1'b1; rd_addr = cp_plus2[PartIdxW-1:0]; end_rd_d = 1'b1;
                    end else begin
                      end_d = s_pts; end_rd_d = 1'b0;
                    end
                  end
                end
              end
            end
          end
          do_bnd = s_roff + 34'd1 == s_clen;
        end
        default: begin
          phase_d = PH_HEADER;
        end
      endcase
      // end of header or record
      if (do_bnd && !stop_d) begin
        if (s_decl < off1) begin
          ev = mk_err(ERR_LENGTH, '0); stop_d = 1'b1;
        end else if (bnd_rem == '0) begin
          ev = '{v: 1'b1, kind: KIND_ACCEPT, rec: '0, err: ERR_NONE};
          stop_d = 1'b1;
        end else if (bnd_rem < 34'd8) begin
          ev = mk_err(ERR_TRUNC, '0); stop_d = 1'b1;
        end else begin
          phase_d = PH_RECHDR;
          roff_d  = '0;
        end
      end
    end
  end

  assign push_o         = acc && (sof || pt || ev.v);
  assign cmd_o.sof      = sof;
  assign cmd_o.pt       = pt;
  assign cmd_o.pt_first = pt_first;
  assign cmd_o.pt_last  = pt_last;
  assign cmd_o.pt_rec   = s_cur;
  assign cmd_o.pt_part  = 8'(s_cp);
  assign cmd_o.x_bits   = s_px;
  assign cmd_o.y_bits   = ba_n;
  assign cmd_o.ev       = ev;

  always_ff @(posedge clk_i) begin
    if (acc && wr_en) tbl_q[wr_addr] <= le;
    if (acc && rd_en) tbl_rd_q <= tbl_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; off_q <= '0; decl_q <= '0; roff_q <= '0; clen_q <= '0;
      pend_q <= 1'b0; stop_q <= 1'b0; exp_q <= 32'd1; cur_q <= '0; parts_q <= '0;
      pts_q <= '0; cp_q <= '0; ba_q <= '0; px_q <= '0; start_q <= '0; end_q <= '0;
      pent_q <= '0; end_rd_q <= 1'b0;
    end else if (acc) begin
      phase_q <= phase_d; off_q <= off_d; decl_q <= decl_d; roff_q <= roff_d;
      clen_q <= clen_d; pend_q <= pend_d; stop_q <= stop_d; exp_q <= exp_d;
      cur_q <= cur_d; parts_q <= parts_d; pts_q <= pts_d; cp_q <= cp_d;
      ba_q <= ba_d; px_q <= px_d; start_q <= start_d; end_q <= end_d;
      pent_q <= pent_d; end_rd_q <= end_rd_d;
    end
  end

endmodule

@@ rtl/core/psv_back.sv @@
module psv_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  psv_pkg::cmd_t cmd_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    kind_o,
  output logic [31:0]   rec_no_o,
  output logic [7:0]    ring_index_o,
  output logic          exterior_o,
  output logic [3:0]    err_code_o,
  output logic          last_of_run_o
);
  import psv_pkg::*;

  typedef struct packed {
    logic        sign;
    logic [52:0] mag;
  } fix_t;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_CONV_X    = 7'b0000010,
    ST_CONV_Y    = 7'b0000100,
    ST_MUL       = 7'b0001000,
    ST_DRAIN     = 7'b0010000,
    ST_EMIT_RING = 7'b0100000,
    ST_EMIT_EV   = 7'b1000000
  } st_e;

  // conversion of a double to sign and magnitude, round half away
  function automatic fix_t to_fixed(logic [63:0] bits);
    fix_t        f;
    logic [10:0] ex;
    logic [52:0] m;
    logic [53:0] s;
    int          k;
    ex = bits[62:52];
    m  = {1'b0, bits[51:0]};
    if (ex == '0) ex = 11'd1;
    else m[52] = 1'b1;
    k = 1075 - int'(ex) - FracBits;
    if (k < 1) k = 1;
    f.sign = bits[63];
    if (k >= 63) begin
      f.mag = '0;
    end else begin
      s     = {1'b0, m} + (54'd1 << (k - 1));
      f.mag = 53'(s >> k);
    end
    return f;
  endfunction

  st_e          st_q, st_d;
  cmd_t         cmd_q;
  logic         discard_q, discard_d, closing_q, closing_d;
  fix_t         cx_q, cy, fx_q, fy_q, px_q, py_q, ax_q, ay_q, bx_q, by_q;
  logic [2:0]   step_q;
  logic [63:0]  pp_q;
  logic [1:0]   sh_q;
  logic         neg_q, ppv_q;
  logic [127:0] acc_q, term;
  logic [31:0]  ah, bh;
  fix_t         ma, mb;
  logic         out_free, load;
  logic [1:0]   o_kind;
  logic [31:0]  o_rec;
  logic [7:0]   o_ring;
  logic         o_ext, o_last;
  logic [3:0]   o_err;

  assign cy       = to_fixed(cmd_q.y_bits);
  assign out_free = !out_valid_o || out_ready_i;

  // partial product select: steps 0-3 add ax*by, steps 4-7 subtract bx*ay
  assign ma   = step_q[2] ? bx_q : ax_q;
  assign mb   = step_q[2] ? ay_q : by_q;
  assign ah   = step_q[1] ? {11'b0, ma.mag[52:32]} : ma.mag[31:0];
  assign bh   = step_q[0] ? {11'b0, mb.mag[52:32]} : mb.mag[31:0];
  assign term = {64'b0, pp_q} << {sh_q, 5'b0};

  always_comb begin
    st_d      = st_q;
    discard_d = discard_q;
    closing_d = closing_q;
    pop_o     = 1'b0;
    load      = 1'b0;
    o_kind    = KIND_RING;
    o_rec     = cmd_q.ev.rec;
    o_ring    = '0;
    o_ext     = 1'b0;
    o_err     = ERR_NONE;
    o_last    = 1'b1;
    unique case (st_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (!discard_q || cmd_i.sof) begin
            discard_d = 1'b0;
            if (cmd_i.pt) st_d = ST_CONV_X;
            else if (cmd_i.ev.v) st_d = ST_EMIT_EV;
          end
        end
      end
      ST_CONV_X: st_d = ST_CONV_Y;
      ST_CONV_Y: begin
        closing_d = cmd_q.pt_first;
        if (cmd_q.pt_first && !cmd_q.pt_last) begin
          st_d = cmd_q.ev.v ? ST_EMIT_EV : ST_IDLE;
        end else begin
          st_d = ST_MUL;
        end
      end
      ST_MUL: if (step_q == 3'd7) st_d = ST_DRAIN;
      ST_DRAIN: begin
        if (cmd_q.pt_last && !closing_q) begin
          closing_d = 1'b1;
          st_d      = ST_MUL;
        end else if (cmd_q.pt_last) begin
          st_d = ST_EMIT_RING;
        end else begin
          st_d = cmd_q.ev.v ? ST_EMIT_EV : ST_IDLE;
        end
      end
      ST_EMIT_RING: begin
        if (out_free) begin
          load  = 1'b1;
          o_rec = cmd_q.pt_rec;
          if (acc_q == '0) begin
            o_kind    = KIND_ERROR;
            o_err     = ERR_DEGENERATE;
            discard_d = 1'b1;
            st_d      = ST_IDLE;
          end else begin
            o_ring = cmd_q.pt_part;
            o_ext  = acc_q[127];
            o_last = !cmd_q.ev.v;
            st_d   = cmd_q.ev.v ? ST_EMIT_EV : ST_IDLE;
          end
        end
      end
      ST_EMIT_EV: begin
        if (out_free) begin
          load   = 1'b1;
          o_kind = cmd_q.ev.kind;
          o_err  = cmd_q.ev.err;
          st_d   = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      discard_q   <= 1'b0;
      closing_q   <= 1'b0;
      step_q      <= '0;
      ppv_q       <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      st_q      <= st_d;
      discard_q <= discard_d;
      closing_q <= closing_d;
      ppv_q     <= st_q == ST_MUL;
      step_q    <= (st_q == ST_MUL) ? step_q + 3'd1 : '0;
      if (load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= cmd_i;
    if (st_q == ST_CONV_X) cx_q <= to_fixed(cmd_q.x_bits);
    if (st_q == ST_CONV_Y) begin
      px_q <= cx_q;
      py_q <= cy;
      if (cmd_q.pt_first) begin
        fx_q <= cx_q; fy_q <= cy;
        ax_q <= cx_q; ay_q <= cy; bx_q <= cx_q; by_q <= cy;
      end else begin
        ax_q <= px_q; ay_q <= py_q; bx_q <= cx_q; by_q <= cy;
      end
    end
    if (st_q == ST_DRAIN && cmd_q.pt_last && !closing_q) begin
      ax_q <= px_q; ay_q <= py_q; bx_q <= fx_q; by_q <= fy_q;
    end
    if (st_q == ST_MUL) begin
      pp_q  <= ah * bh;
      sh_q  <= 2'(step_q[1]) + 2'(step_q[0]);
      neg_q <= ma.sign ^ mb.sign ^ step_q[2];
    end
    if (st_q == ST_CONV_Y && cmd_q.pt_first) acc_q <= '0;
    else if (ppv_q) acc_q <= neg_q ? acc_q - term : acc_q + term;
    if (load) begin
      kind_o        <= o_kind;
      rec_no_o      <= o_rec;
      ring_index_o  <= o_ring;
      exterior_o    <= o_ext;
      err_code_o    <= o_err;
      last_of_run_o <= o_last;
    end
  end

endmodule

@@ rtl/core/polygon_shapefile_validator.sv @@
// Streaming polygon shapefile checker.
// Input channel (in_valid_i/in_ready_o): one file byte per item, with
// start_of_file_i set on byte 0 of each file; that byte clears all parse state.
// Output channel (out_valid_o/out_ready_i): ring roles, file accepted, or the
// first error, with last_of_run_o set on the final result of a given byte.
// cfg_we_i/cfg_wdata_i load the real file length; write it while idle.
// Throughput: one byte per cycle while the queue has room. The parser
// classifies each byte in the cycle it is taken and hands points and results
// to a four-entry queue. The area engine pops a point only while idle,
// converts it and runs each shoelace edge through one 32x32 multiplier before
// it pops again; for a ring's closing point it also adds the closing edge.
// Header and record results pass through the queue and the output register.
// A zero-area ring ends the file: later results are dropped until the next
// file start. When the receiver stalls, the output register holds, the queue
// fills and in_ready_o falls after at most four more queued items (points,
// results or file starts).
// Reset empties the queue and returns the parser to the header phase, with the
// file length register at zero.
module polygon_shapefile_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] rec_no_o,
  output logic [7:0]  ring_index_o,
  output logic        exterior_o,
  output logic [3:0]  err_code_o,
  output logic        last_of_run_o,
  input  logic        cfg_we_i,
  input  logic [32:0] cfg_wdata_i
);
  import psv_pkg::*;

  logic [32:0] flen_q;
  logic        q_full, q_empty, push, pop;
  cmd_t        push_cmd, pop_cmd;

  // file length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flen_q <= '0;
    end else if (cfg_we_i) begin
      flen_q <= cfg_wdata_i;
    end
  end

  // byte parser: header, record headers, part table, coordinate checks
  psv_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .start_of_file_i(start_of_file_i),
    .file_length_i  (flen_q),
    .q_full_i       (q_full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  psv_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .pop_data_o (pop_cmd),
    .empty_o    (q_empty)
  );

  // shoelace engine and result register
  psv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (pop_cmd),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .rec_no_o     (rec_no_o),
    .ring_index_o (ring_index_o),
    .exterior_o   (exterior_o),
    .err_code_o   (err_code_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule
